@@ rtl/bssid_blocklist_table_defines.svh @@
// Assertion macros shared by the blocklist table checkers.
// No dependencies; included by the checker file.
`ifndef BSSID_BLOCKLIST_TABLE_DEFINES_SVH
`define BSSID_BLOCKLIST_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bbt_pkg.sv @@
// Shared types and constants for the BSSID blocklist table.
// No dependencies; imported by bbt_if, bbt_ctrl, bbt_datapath and the top level.
`default_nettype none

package bbt_pkg;

    localparam int DEF_TABLE_SLOTS = 16;

    localparam int ADDR_W     = 48;
    localparam int REASON_W   = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;
    localparam logic [COUNT_W-1:0]  RST_FAIL_THRESHOLD = 8'd3;
    localparam logic [TIME_W-1:0]   RST_EXPIRE_SECONDS = 32'd300;
    localparam logic [REASON_W-1:0] RST_IMMEDIATE_REASON = 16'd17;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_SECONDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMMEDIATE_REASON = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_FAIL    = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_LIST    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
        logic               blocked;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic chk_valid;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;
        logic  stall;
        logic  out_can_load;
        logic  list_empty;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/bbt_if.sv @@
// Channel interfaces of the blocklist table: item in, result out, config write.
// Depends on bbt_pkg for field widths.
`default_nettype none

interface bbt_item_if import bbt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   bssid;
    logic [REASON_W-1:0] reason_code;
    logic [TIME_W-1:0]   now_seconds;

    modport source (output valid, kind, bssid, reason_code, now_seconds, input ready);
    modport sink   (input valid, kind, bssid, reason_code, now_seconds, output ready);
endinterface

interface bbt_result_if import bbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              updated;
    logic              table_full;
    logic [ADDR_W-1:0] listed_bssid;
    logic              listed_valid;
    logic              last;

    modport source (output valid, updated, table_full, listed_bssid, listed_valid, last,
                    input ready);
    modport sink   (input valid, updated, table_full, listed_bssid, listed_valid, last,
                    output ready);
endinterface

interface bbt_cfg_if import bbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/bbt_ctrl.sv @@
// Table sequencer: takes an item, walks the slots, finishes unless a list emitted.
// Depends on bbt_pkg (t_cmd, t_stat, t_kind).
`default_nettype none

module bbt_ctrl import bbt_pkg::*; #(
    parameter int  TABLE_SLOTS = DEF_TABLE_SLOTS,
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_stat            i_stat,
    output t_cmd                  o_cmd,
    output logic [IDX_W-1:0]      o_rd_idx,
    output logic [IDX_W-1:0]      o_chk_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_issue, n_issue;
    logic              r_issue_on, n_issue_on;
    logic              r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic              rd_en;
    logic              finish;

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_issue_on  = r_issue_on;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        o_in_ready  = 1'b0;
        rd_en       = 1'b0;
        finish      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state     = ST_SCAN;
                    n_issue     = '0;
                    n_issue_on  = 1'b1;
                    n_chk_valid = 1'b0;
                end
            end
            ST_SCAN: begin
                // read stage feeds check stage one slot per cycle; both hold on stall
                if (!i_stat.stall) begin
                    rd_en       = r_issue_on;
                    n_chk_valid = r_issue_on;
                    n_chk_idx   = r_issue;
                    if (r_issue_on) begin
                        if (r_issue == LAST_IDX) begin
                            n_issue_on = 1'b0;
                        end else begin
                            n_issue = r_issue + IDX_W'(1);
                        end
                    end
                    if (r_chk_valid && r_chk_idx == LAST_IDX) begin
                        n_chk_valid = 1'b0;
                        if (i_stat.kind != KIND_LIST || i_stat.list_empty) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (i_stat.out_can_load) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_issue_on  <= 1'b0;
            r_chk_valid <= 1'b0;
            r_chk_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_issue_on  <= n_issue_on;
            r_chk_valid <= n_chk_valid;
            r_chk_idx   <= n_chk_idx;
        end
    end

    assign o_cmd.load_item = o_in_ready && i_in_valid;
    assign o_cmd.rd_en     = rd_en;
    assign o_cmd.chk_valid = r_chk_valid;
    assign o_cmd.finish    = finish;
    assign o_rd_idx        = r_issue;
    assign o_chk_idx       = r_chk_idx;

endmodule

`default_nettype wire

@@ rtl/bbt_datapath.sv @@
// Datapath of the blocklist table: slot memory, used bits, config, scan
// trackers and the result register. Depends on bbt_pkg.
`default_nettype none

module bbt_datapath import bbt_pkg::*; #(
    parameter int  TABLE_SLOTS = DEF_TABLE_SLOTS,
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [IDX_W-1:0]      i_rd_idx,
    input  wire logic [IDX_W-1:0]      i_chk_idx,
    output t_stat                      o_stat,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [ADDR_W-1:0]     i_bssid,
    input  wire logic [REASON_W-1:0]   i_reason_code,
    input  wire logic [TIME_W-1:0]     i_now_seconds,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_updated,
    output logic                       o_table_full,
    output logic [ADDR_W-1:0]          o_listed_bssid,
    output logic                       o_listed_valid,
    output logic                       o_last
);

    // item and config registers
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_bssid;
    logic [REASON_W-1:0] r_reason;
    logic [TIME_W-1:0]   r_now;
    logic [COUNT_W-1:0]  r_fail_threshold;
    logic [TIME_W-1:0]   r_expire;
    logic [REASON_W-1:0] r_imm_reason;

    // slot storage
    logic [TABLE_SLOTS-1:0] r_used, n_used;
    t_entry                 r_mem [TABLE_SLOTS];
    t_entry                 r_rd_data;

    // scan trackers
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic [COUNT_W-1:0] r_found_cnt;
    logic               r_found_blk;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_upd;

    // result register
    logic              r_out_valid;
    logic              r_updated;
    logic              r_table_full;
    logic [ADDR_W-1:0] r_listed_bssid;
    logic              r_listed_valid;
    logic              r_last;

    logic               bssid_nz;
    logic               chk_used;
    logic               addr_hit;
    logic [TIME_W-1:0]  age;
    logic               expired;
    logic               any_after;
    logic               list_emit;
    logic               out_can_load;
    logic               stall;
    logic               chk_go;
    logic               drop_slot;
    logic [IDX_W-1:0]   tgt_idx;
    logic [COUNT_W-1:0] cnt0;
    logic [COUNT_W-1:0] cnt1;
    logic               blk0;
    logic               blk_new;
    logic               fail_store;
    logic               fail_full;
    logic               wr_en;
    t_entry             wr_data;
    logic               fin_updated;

    // check stage
    assign bssid_nz     = (r_bssid != '0);
    assign chk_used     = r_used[i_chk_idx];
    assign addr_hit     = chk_used && (r_rd_data.addr == r_bssid) && bssid_nz;
    assign age          = r_now - r_rd_data.stamp;   // wraps mod 2^32
    assign expired      = chk_used && r_rd_data.blocked && (age >= r_expire);
    assign any_after    = |((r_used >> i_chk_idx) >> 1);
    assign list_emit    = i_cmd.chk_valid && (r_kind == KIND_LIST) && chk_used;
    assign out_can_load = !r_out_valid || i_out_ready;
    assign stall        = list_emit && !out_can_load;
    assign chk_go       = i_cmd.chk_valid && !stall;
    assign drop_slot    = chk_go && (((r_kind == KIND_ENABLE) && addr_hit) ||
                                     ((r_kind == KIND_REFRESH) && expired));

    // failure-report commit
    assign tgt_idx    = r_found ? r_found_idx : r_free_idx;
    assign cnt0       = r_found ? r_found_cnt : '0;
    assign blk0       = r_found && r_found_blk;
    assign cnt1       = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + COUNT_W'(1);
    assign blk_new    = !blk0 && ((cnt1 >= r_fail_threshold) || (r_reason == r_imm_reason));
    assign fail_store = bssid_nz && (r_found || r_free_ok);
    assign fail_full  = bssid_nz && !r_found && !r_free_ok;
    assign wr_en      = i_cmd.finish && (r_kind == KIND_FAIL) && fail_store;

    always_comb begin
        wr_data.addr    = r_bssid;
        wr_data.count   = cnt1;
        wr_data.stamp   = r_now;
        wr_data.blocked = blk0 || blk_new;
    end

    always_comb begin
        case (r_kind)
            KIND_FAIL:    fin_updated = fail_store && blk_new;
            KIND_ENABLE:  fin_updated = r_upd;
            KIND_REFRESH: fin_updated = r_upd;
            KIND_LIST:    fin_updated = 1'b0;
            default:      fin_updated = 1'b0;
        endcase
    end

    always_comb begin
        n_used = r_used;
        if (wr_en && !r_found) begin
            n_used[tgt_idx] = 1'b1;
        end
        if (drop_slot) begin
            n_used[i_chk_idx] = 1'b0;
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[tgt_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used           <= '0;
            r_fail_threshold <= RST_FAIL_THRESHOLD;
            r_expire         <= RST_EXPIRE_SECONDS;
            r_imm_reason     <= RST_IMMEDIATE_REASON;
            r_found          <= 1'b0;
            r_free_ok        <= 1'b0;
            r_upd            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_used <= n_used;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FAIL_THRESHOLD:   r_fail_threshold <= i_cfg_data[COUNT_W-1:0];
                    CFG_EXPIRE_SECONDS:   r_expire         <= i_cfg_data[TIME_W-1:0];
                    CFG_IMMEDIATE_REASON: r_imm_reason     <= i_cfg_data[REASON_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_item) begin
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
                r_upd     <= 1'b0;
            end else if (chk_go) begin
                if (r_kind == KIND_FAIL) begin
                    if (addr_hit) begin
                        r_found <= 1'b1;
                    end
                    if (!chk_used && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                    end
                end
                if (drop_slot) begin
                    r_upd <= 1'b1;
                end
            end
            if (i_cmd.finish || (chk_go && list_emit)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind   <= t_kind'(i_kind);
            r_bssid  <= i_bssid;
            r_reason <= i_reason_code;
            r_now    <= i_now_seconds;
        end
        if (chk_go && (r_kind == KIND_FAIL)) begin
            if (addr_hit) begin
                r_found_idx <= i_chk_idx;
                r_found_cnt <= r_rd_data.count;
                r_found_blk <= r_rd_data.blocked;
            end
            if (!chk_used && !r_free_ok) begin
                r_free_idx <= i_chk_idx;
            end
        end
        if (i_cmd.finish) begin
            r_updated      <= fin_updated;
            r_table_full   <= (r_kind == KIND_FAIL) && fail_full;
            r_listed_bssid <= '0;
            r_listed_valid <= 1'b0;
            r_last         <= 1'b1;
        end else if (chk_go && list_emit) begin
            r_updated      <= 1'b0;
            r_table_full   <= 1'b0;
            r_listed_bssid <= r_rd_data.addr;
            r_listed_valid <= 1'b1;
            r_last         <= !any_after;
        end
    end

    assign o_stat.kind         = r_kind;
    assign o_stat.stall        = stall;
    assign o_stat.out_can_load = out_can_load;
    assign o_stat.list_empty   = ~|r_used;

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_updated      = r_updated;
    assign o_table_full   = r_table_full;
    assign o_listed_bssid = r_listed_bssid;
    assign o_listed_valid = r_listed_valid;
    assign o_last         = r_last;

endmodule

`default_nettype wire

@@ rtl/bssid_blocklist_table.sv @@
// Kinds 0-2 give one result each; a list gives one per used slot, or one if the table is empty.
// A new item is taken only once the walk of the last one is done; the walk reads one slot
//   per cycle unless a list result waiting for the sink stalls it.
// Reset: synchronous, active low; empties the table and loads the config reset values.
// Depends on bbt_pkg, bbt_if, bbt_ctrl and bbt_datapath.
`default_nettype none

// Every item walks all slots in order: read one slot per cycle unless a list
// result stalls, then check it from the read register. The walk finds a match
// or the lowest free slot for a failure report, drops matched or expired
// slots for re-enable and refresh, and emits used addresses for a list. The
// input is taken only while the sequencer is idle; the result register lets
// a finished result wait for the sink while the next item is already taken.
module bssid_blocklist_table import bbt_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bbt_item_if.sink    i_item,
    bbt_result_if.source o_result,
    bbt_cfg_if.sink     i_cfg
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] chk_idx;

    // sequencer: input handshake, slot walk, finish step
    bbt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx),
        .o_chk_idx  (chk_idx)
    );

    // storage, compare logic, config and result register
    bbt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_idx       (rd_idx),
        .i_chk_idx      (chk_idx),
        .o_stat         (stat),
        .i_kind         (i_item.kind),
        .i_bssid        (i_item.bssid),
        .i_reason_code  (i_item.reason_code),
        .i_now_seconds  (i_item.now_seconds),
        .i_cfg_valid    (i_cfg.valid),
        .o_cfg_ready    (i_cfg.ready),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .o_updated      (o_result.updated),
        .o_table_full   (o_result.table_full),
        .o_listed_bssid (o_result.listed_bssid),
        .o_listed_valid (o_result.listed_valid),
        .o_last         (o_result.last)
    );

endmodule

`default_nettype wire

@@ rtl/bbt_checker.sv @@
// Port-level checks for the blocklist table, bound to the top level.
// Depends on bssid_blocklist_table_defines.svh.
`default_nettype none

`include "bssid_blocklist_table_defines.svh"

module bbt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_updated,
    input wire logic        i_table_full,
    input wire logic [47:0] i_listed_bssid,
    input wire logic        i_listed_valid,
    input wire logic        i_last
);

    // a waiting result holds until taken
    `BBT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_listed_bssid) && $stable(i_updated) && $stable(i_last), "result changed while stalled")

    // the walk keeps the input closed right after a transfer
    `BBT_ASSERT_NXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken during walk")

    // list results carry no update or full flag
    `BBT_ASSERT_IMP(a_list_flags, i_clk, i_rst_n, i_out_valid && i_listed_valid, !i_updated && !i_table_full, "list result with status flags")

    // single results always close their item
    `BBT_ASSERT_IMP(a_single_last, i_clk, i_rst_n, i_out_valid && !i_listed_valid, i_last, "single result without last")

    // a full table never reports an update
    `BBT_ASSERT_IMP(a_full_no_upd, i_clk, i_rst_n, i_out_valid && i_table_full, !i_updated, "table full with update")

endmodule

bind bssid_blocklist_table bbt_checker u_bbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_updated      (o_result.updated),
    .i_table_full   (o_result.table_full),
    .i_listed_bssid (o_result.listed_bssid),
    .i_listed_valid (o_result.listed_valid),
    .i_last         (o_result.last)
);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for bssid_blocklist_table: random-stall driver and monitor,
// with a predictor of the slot table kept in step with every transfer.
// Depends on bbt_pkg, bbt_if and the blocklist table RTL.
`timescale 1ns / 1ps

module testbench;
    import bbt_pkg::*;

    localparam int SLOTS       = DEF_TABLE_SLOTS;
    localparam int POOL_SIZE   = 20;   // a few more addresses than slots, so the table fills
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 400;  // long sink hold-off, well past what fills the block
    localparam int DRAIN_WAIT  = 40;   // wait before the verdict for stray results
    localparam int STALL_LIMIT = 3000; // cycles with no transfer on any channel
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   bssid;
        logic [REASON_W-1:0] reason;
        logic [TIME_W-1:0]   now;
    } t_request;

    typedef struct packed {
        logic              updated;
        logic              table_full;
        logic [ADDR_W-1:0] listed_bssid;
        logic              listed_valid;
        logic              last;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    bbt_item_if   item_ch ();
    bbt_result_if result_ch ();
    bbt_cfg_if    cfg_ch ();

    bssid_blocklist_table #(
        .TABLE_SLOTS (SLOTS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predicted table contents and register copies
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]  thr_copy;
    logic [TIME_W-1:0]   expire_copy;
    logic [REASON_W-1:0] imm_copy;

    bit                  tbl_used    [SLOTS];
    logic [ADDR_W-1:0]   tbl_addr    [SLOTS];
    logic [COUNT_W-1:0]  tbl_count   [SLOTS];
    logic [TIME_W-1:0]   tbl_stamp   [SLOTS];
    bit                  tbl_blocked [SLOTS];

    t_request item_backlog[$];      // items waiting for the driver
    t_outcome expected_results[$];  // predicted results, oldest first

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_s;     // running time for the random items

    bit no_idle;
    bit hold_req;
    bit hold_done;
    int hold_left;
    int mismatch_count;
    int quiet_cycles;

    // Append one predicted result at the tail.
    task automatic queue_expected(input t_outcome o);
        expected_results.insert(expected_results.size(), o);
    endtask

    // Append one item for the driver at the tail.
    task automatic queue_item(input t_request r);
        item_backlog.insert(item_backlog.size(), r);
    endtask

    // Apply one accepted item to the predicted table and queue what it should produce.
    task automatic predict_blocklist(input t_request r);
        int       hit;
        int       spot;
        int       n;
        t_outcome o;
        logic [TIME_W-1:0] age;
        hit  = -1;
        spot = -1;
        n    = 0;
        o    = '0;
        o.last = 1'b1;
        case (r.kind)
            KIND_FAIL: begin
                // zero address: no change, nothing flagged
                if (r.bssid != '0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && tbl_used[i] && tbl_addr[i] == r.bssid) hit = i;
                    if (hit < 0) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (spot < 0 && !tbl_used[i]) spot = i;
                        if (spot < 0) begin
                            o.table_full = 1'b1;
                        end else begin
                            tbl_used[spot]    = 1'b1;
                            tbl_addr[spot]    = r.bssid;
                            tbl_count[spot]   = '0;
                            tbl_blocked[spot] = 1'b0;
                            hit = spot;
                        end
                    end
                    if (hit >= 0) begin
                        if (tbl_count[hit] != COUNT_MAX)
                            tbl_count[hit] = tbl_count[hit] + COUNT_W'(1);
                        tbl_stamp[hit] = r.now;
                        // only the transition into blocked counts as an update
                        if (!tbl_blocked[hit] &&
                            (tbl_count[hit] >= thr_copy || r.reason == imm_copy)) begin
                            tbl_blocked[hit] = 1'b1;
                            o.updated = 1'b1;
                        end
                    end
                end
                queue_expected(o);
            end
            KIND_ENABLE: begin
                if (r.bssid != '0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && tbl_used[i] && tbl_addr[i] == r.bssid) hit = i;
                    if (hit >= 0) begin
                        tbl_used[hit] = 1'b0;
                        o.updated = 1'b1;
                    end
                end
                queue_expected(o);
            end
            KIND_REFRESH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    age = r.now - tbl_stamp[i];   // wraps modulo 2^32
                    if (tbl_used[i] && tbl_blocked[i] && age >= expire_copy) begin
                        tbl_used[i] = 1'b0;
                        o.updated = 1'b1;
                    end
                end
                queue_expected(o);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_used[i]) begin
                        queue_expected({1'b0, 1'b0, tbl_addr[i], 1'b1, 1'b0});
                        n++;
                    end
                end
                if (n == 0) queue_expected(o);
                else expected_results[expected_results.size()-1].last = 1'b1;
            end
        endcase
    endtask

    // Random item: mostly failure reports against a small address pool so that
    // entries get hit, blocked, expired and the table fills; the rest is noise.
    function automatic t_request draw_request();
        t_request r;
        int       pick;
        logic [63:0] w;
        pick = $urandom_range(99);
        r.kind = (pick < 55) ? KIND_FAIL : (pick < 70) ? KIND_ENABLE :
                 (pick < 85) ? KIND_REFRESH : KIND_LIST;
        pick = $urandom_range(99);
        w = {$urandom, $urandom};
        if (pick < 5) r.bssid = '0;
        else if (pick < 15) r.bssid = w[ADDR_W-1:0];
        else r.bssid = addr_pool[$urandom_range(POOL_SIZE-1)];
        r.reason = ($urandom_range(99) < 25) ? imm_copy : REASON_W'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 5) clock_s = $urandom;
        else clock_s = clock_s + TIME_W'($urandom_range(60));
        r.now = clock_s;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Item driver: offers queued items with random gaps. Prediction runs on
    // the fields that were actually transferred.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                predict_blocklist({t_kind'(item_ch.kind), item_ch.bssid,
                                   item_ch.reason_code, item_ch.now_seconds});
            if (!item_ch.valid || item_ch.ready) begin
                if (item_backlog.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    item_ch.valid       <= 1'b1;
                    item_ch.kind        <= item_backlog[0].kind;
                    item_ch.bssid       <= item_backlog[0].bssid;
                    item_ch.reason_code <= item_backlog[0].reason;
                    item_ch.now_seconds <= item_backlog[0].now;
                    void'(item_backlog.pop_front());
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random ready, plus one long hold-off on request so the
    // block backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every transfer is checked against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = {result_ch.updated, result_ch.table_full, result_ch.listed_bssid,
                   result_ch.listed_valid, result_ch.last};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: mismatch exp none",
                              " | got upd=%0b full=%0b addr=%012h lv=%0b last=%0b"},
                             $time, got.updated, got.table_full, got.listed_bssid,
                             got.listed_valid, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got.updated !== want.updated || got.table_full !== want.table_full ||
                    got.listed_bssid !== want.listed_bssid ||
                    got.listed_valid !== want.listed_valid || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch exp upd=%0b full=%0b addr=%012h lv=%0b last=%0b",
                                  " | got upd=%0b full=%0b addr=%012h lv=%0b last=%0b"},
                                 $time, want.updated, want.table_full, want.listed_bssid,
                                 want.listed_valid, want.last, got.updated, got.table_full,
                                 got.listed_bssid, got.listed_valid, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles without a transfer on any channel.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until the driver is empty, every predicted result has arrived and
    // the block is back to idle (a list can finish its results before its walk).
    task automatic wait_drained();
        while (item_backlog.size() != 0 || item_ch.valid || expected_results.size() != 0 ||
               !item_ch.ready)
            @(posedge i_clk);
    endtask

    // One register write over the config channel; the copy follows at the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FAIL_THRESHOLD:   thr_copy    = value[COUNT_W-1:0];
            CFG_EXPIRE_SECONDS:   expire_copy = value[TIME_W-1:0];
            CFG_IMMEDIATE_REASON: imm_copy    = value[REASON_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) queue_item(draw_request());
        wait_drained();
    endtask

    function automatic t_request mk(input t_kind k, input logic [ADDR_W-1:0] a,
                                    input logic [REASON_W-1:0] rc,
                                    input logic [TIME_W-1:0] t);
        return {k, a, rc, t};
    endfunction

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases under several
    // register settings. Each phase drains completely before registers change.
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] w;
        bit          leftover;

        // every block input known from time zero
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = '0;
        item_ch.bssid       = '0;
        item_ch.reason_code = '0;
        item_ch.now_seconds = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        no_idle             = 1'b0;
        hold_req            = 1'b0;
        mismatch_count      = 0;
        quiet_cycles        = 0;
        clock_s             = '0;

        thr_copy    = RST_FAIL_THRESHOLD;
        expire_copy = RST_EXPIRE_SECONDS;
        imm_copy    = RST_IMMEDIATE_REASON;
        for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            w = {$urandom, $urandom};
            addr_pool[i] = (w[ADDR_W-1:0] == '0) ? ADDR_W'(1) : w[ADDR_W-1:0];
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values.
        queue_item(mk(KIND_LIST,    '0, '0, '0));          // empty table list
        queue_item(mk(KIND_FAIL,    '0, 16'd17, 32'd5));   // zero address
        queue_item(mk(KIND_ENABLE,  '0, '0, '0));          // zero address
        queue_item(mk(KIND_ENABLE,  48'h0123_4567_89AB, '0, '0)); // unknown
        queue_item(mk(KIND_FAIL,    '1, 16'h0000, 32'hFFFF_FF00));
        queue_item(mk(KIND_FAIL,    '1, 16'd17, 32'hFFFF_FF00)); // immediate block
        queue_item(mk(KIND_FAIL,    '1, 16'h0000, 32'hFFFF_FF00)); // already blocked
        queue_item(mk(KIND_REFRESH, '0, '0, 32'h0000_0100)); // age across a wrap
        queue_item(mk(KIND_FAIL,    48'h1, 16'hFFFF, 32'hFFFF_FFFF));
        for (int k = 0; k < SLOTS - 1; k++)
            queue_item(mk(KIND_FAIL, {16'hA5A5, 32'(k + 2)}, 16'h1234, '0));
        queue_item(mk(KIND_FAIL,    48'h8000_0000_0000, '0, '0)); // table full
        queue_item(mk(KIND_LIST,    '0, '0, '0));          // full list
        queue_item(mk(KIND_ENABLE,  48'h1, '0, '0));       // known address
        wait_drained();

        // Random, reset values, with the long sink hold-off while items keep coming.
        hold_req = 1'b1;
        run_random(50);

        // Low extremes: threshold 1, everything blocked expires, reason 0 blocks.
        write_reg(CFG_FAIL_THRESHOLD, 32'd1);
        write_reg(CFG_EXPIRE_SECONDS, 32'd0);
        write_reg(CFG_IMMEDIATE_REASON, 32'd0);
        no_idle = 1'b1;
        run_random(45);
        no_idle = 1'b0;

        // High extremes.
        write_reg(CFG_FAIL_THRESHOLD, 32'd255);
        write_reg(CFG_EXPIRE_SECONDS, 32'hFFFF_FFFF);
        write_reg(CFG_IMMEDIATE_REASON, 32'h0000_FFFF);
        run_random(45);

        // Threshold zero blocks on every report.
        write_reg(CFG_FAIL_THRESHOLD, 32'd0);
        write_reg(CFG_EXPIRE_SECONDS, $urandom_range(200));
        write_reg(CFG_IMMEDIATE_REASON, $urandom_range(16'hFFFF));
        run_random(45);

        // Mid-range settings.
        write_reg(CFG_FAIL_THRESHOLD, $urandom_range(5, 2));
        write_reg(CFG_EXPIRE_SECONDS, $urandom_range(400, 30));
        write_reg(CFG_IMMEDIATE_REASON, $urandom_range(16'hFFFF));
        run_random(48);

        // Let anything stray show up before the verdict.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        leftover = (expected_results.size() != 0);
        if (leftover)
            $display("%0t: %0d predicted results never arrived", $time, expected_results.size());

        if (mismatch_count == 0 && !leftover) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
